FILE: rtl/l4px_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// L4 protocol extract package
// Shared item types, ethertype constants and frame class codes.
// ----------------------------------------------------------------------------
package l4px_pkg;

  localparam int unsigned MaxVlanTags = 2;

  localparam logic [15:0] ETYPE_CTAG = 16'h8100;
  localparam logic [15:0] ETYPE_STAG = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

  localparam logic [2:0] CLASS_IPV4     = 3'd0;
  localparam logic [2:0] CLASS_IPV6     = 3'd1;
  localparam logic [2:0] CLASS_OTHER    = 3'd2;
  localparam logic [2:0] CLASS_IP_SHORT = 3'd3;
  localparam logic [2:0] CLASS_L2_SHORT = 3'd4;

  localparam logic [5:0] HDR_START_RST = 6'd14;
  localparam logic [6:0] OFFSET_MAX    = 7'd127;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [7:0] protocol;
    logic [2:0] frame_class;
  } out_item_t;

  function automatic logic is_tag_type(input logic [15:0] et);
    return (et == ETYPE_CTAG) || (et == ETYPE_STAG);
  endfunction

endpackage

FILE: rtl/ethernet_l4_protocol_extract.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ethernet L4 protocol extract
// Byte-wide frame parser reporting the IP protocol and a frame class.
// ----------------------------------------------------------------------------
// One frame byte is taken per cycle. Up to MAX_VLAN_TAGS 802.1Q/802.1AD tags
// are skipped; the IPv4 protocol or IPv6 next header is captured. On the byte
// marked end_of_frame one result item is written to the output register and
// shows up on the next cycle. Bytes that are not the last one are taken every
// cycle even while a result waits; a last byte waits only while the output
// register is full and not being drained.
module ethernet_l4_protocol_extract #(
  parameter int unsigned MAX_VLAN_TAGS = l4px_pkg::MaxVlanTags
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  l4px_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output l4px_pkg::out_item_t  out_data_o
);
  import l4px_pkg::*;

  logic      in_accept;
  logic      out_free;
  out_item_t result;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = out_free || !in_data_i.end_of_frame;
  assign in_accept  = in_valid_i && in_ready_o;

  l4px_parser #(
    .MAX_VLAN_TAGS(MAX_VLAN_TAGS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .data_i   (in_data_i),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept && in_data_i.end_of_frame) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && in_data_i.end_of_frame) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.end_of_frame |=> out_valid_o)
    else $error("last byte produced no result");

  a_last_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("last byte stalled with free output");

  a_proto_zero_when_not_ip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_class != CLASS_IPV4
      && out_data_o.frame_class != CLASS_IPV6 |-> out_data_o.protocol == 8'd0)
    else $error("protocol set for non-IP class");

  a_class_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.frame_class <= CLASS_L2_SHORT)
    else $error("frame class out of range");

endmodule

FILE: rtl/l4px_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// L4 protocol extract parser
// Per-frame byte offset and header state; classifies the frame on its last
// byte.
// ----------------------------------------------------------------------------
module l4px_parser #(
  parameter int unsigned MAX_VLAN_TAGS = l4px_pkg::MaxVlanTags
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  l4px_pkg::in_item_t   data_i,
  output l4px_pkg::out_item_t  result_o
);
  import l4px_pkg::*;

  localparam logic [1:0] PH_ETH = 2'd0;
  localparam logic [1:0] PH_TAG = 2'd1;
  localparam logic [1:0] PH_L3  = 2'd2;

  localparam logic [2:0] MaxTags = 3'(MAX_VLAN_TAGS);

  logic [6:0]  offset_q, offset_d;
  logic [15:0] ether_type_q, ether_type_d;
  logic [5:0]  hdr_start_q, hdr_start_d;
  logic [1:0]  tags_q, tags_d;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  proto_q, proto_d;

  logic [15:0] et_n;
  logic [5:0]  hs_n;
  logic [1:0]  tags_n;
  logic [1:0]  phase_n;
  logic [7:0]  proto_n;

  logic [7:0] off8;
  logic [7:0] hs8;
  logic [7:0] hs8_n;
  logic [7:0] length;
  logic [7:0] b;

  assign b      = data_i.frame_byte;
  assign off8   = {1'b0, offset_q};
  assign hs8    = {2'b00, hdr_start_q};
  assign hs8_n  = {2'b00, hs_n};
  assign length = off8 + 8'd1;

  always_comb begin
    et_n    = ether_type_q;
    hs_n    = hdr_start_q;
    tags_n  = tags_q;
    phase_n = phase_q;
    proto_n = proto_q;
    case (phase_q)
      PH_ETH: begin
        if (off8 == 8'd12) begin
          et_n = {b, ether_type_q[7:0]};
        end else if (off8 == 8'd13) begin
          et_n = {ether_type_q[15:8], b};
          phase_n = (is_tag_type(et_n) && ({1'b0, tags_q} < MaxTags)) ? PH_TAG : PH_L3;
        end
      end
      PH_TAG: begin
        if (off8 == hs8 + 8'd2) begin
          et_n = {b, ether_type_q[7:0]};
        end else if (off8 == hs8 + 8'd3) begin
          et_n    = {ether_type_q[15:8], b};
          hs_n    = hdr_start_q + 6'd4;
          tags_n  = tags_q + 2'd1;
          phase_n = (is_tag_type(et_n) && ({1'b0, tags_n} < MaxTags)) ? PH_TAG : PH_L3;
        end
      end
      default: begin
        if (ether_type_q == ETYPE_IPV4 && off8 == hs8 + 8'd9) begin
          proto_n = b;
        end else if (ether_type_q == ETYPE_IPV6 && off8 == hs8 + 8'd6) begin
          proto_n = b;
        end
      end
    endcase
  end

  always_comb begin
    result_o.protocol    = 8'd0;
    result_o.frame_class = CLASS_OTHER;
    if (phase_n != PH_L3) begin
      result_o.frame_class = CLASS_L2_SHORT;
    end else if (et_n == ETYPE_IPV4) begin
      if (length >= hs8_n + 8'd20) begin
        result_o.frame_class = CLASS_IPV4;
        result_o.protocol    = proto_n;
      end else begin
        result_o.frame_class = CLASS_IP_SHORT;
      end
    end else if (et_n == ETYPE_IPV6) begin
      if (length >= hs8_n + 8'd40) begin
        result_o.frame_class = CLASS_IPV6;
        result_o.protocol    = proto_n;
      end else begin
        result_o.frame_class = CLASS_IP_SHORT;
      end
    end
  end

  always_comb begin
    if (data_i.end_of_frame) begin
      offset_d     = 7'd0;
      ether_type_d = 16'd0;
      hdr_start_d  = HDR_START_RST;
      tags_d       = 2'd0;
      phase_d      = PH_ETH;
      proto_d      = 8'd0;
    end else begin
      offset_d     = (offset_q == OFFSET_MAX) ? offset_q : offset_q + 7'd1;
      ether_type_d = et_n;
      hdr_start_d  = hs_n;
      tags_d       = tags_n;
      phase_d      = phase_n;
      proto_d      = proto_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q     <= 7'd0;
      ether_type_q <= 16'd0;
      hdr_start_q  <= HDR_START_RST;
      tags_q       <= 2'd0;
      phase_q      <= PH_ETH;
      proto_q      <= 8'd0;
    end else if (accept_i) begin
      offset_q     <= offset_d;
      ether_type_q <= ether_type_d;
      hdr_start_q  <= hdr_start_d;
      tags_q       <= tags_d;
      phase_q      <= phase_d;
      proto_q      <= proto_d;
    end
  end

endmodule

FILE: sim/l4px_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// L4 protocol extract checker
// Watches both channels of the frame parser, tracks the parse of every
// accepted frame byte and compares each result item with the expected one.
// ----------------------------------------------------------------------------
module l4px_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  l4px_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  l4px_pkg::out_item_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import l4px_pkg::*;

  typedef enum logic [1:0] {PH_ETH, PH_TAG, PH_L3} parse_phase_e;

  logic [6:0]   cur_offset;
  logic [15:0]  cur_type;
  logic [5:0]   tag_base;
  logic [1:0]   tag_count;
  parse_phase_e phase;
  logic [7:0]   ip_proto;

  out_item_t    class_q[$];

  function automatic parse_phase_e after_type(input logic [15:0] et, input logic [1:0] tags);
    if (((et == ETYPE_CTAG) || (et == ETYPE_STAG)) && (tags < MaxVlanTags)) begin
      return PH_TAG;
    end
    return PH_L3;
  endfunction

  task automatic clear_frame();
    cur_offset = '0;
    cur_type   = '0;
    tag_base   = HDR_START_RST;
    tag_count  = '0;
    phase      = PH_ETH;
    ip_proto   = '0;
  endtask

  task automatic parse_byte(input in_item_t it, output bit done, output out_item_t res);
    int         pos;
    int         base;
    logic [7:0] b;
    b    = it.frame_byte;
    pos  = int'(cur_offset);
    base = int'(tag_base);
    done = 1'b0;
    res  = '0;
    case (phase)
      PH_ETH: begin
        if (pos == 12) begin
          cur_type[15:8] = b;
        end else if (pos == 13) begin
          cur_type[7:0] = b;
          phase = after_type(cur_type, tag_count);
        end
      end
      PH_TAG: begin
        if (pos == base + 2) begin
          cur_type[15:8] = b;
        end else if (pos == base + 3) begin
          cur_type[7:0] = b;
          tag_base  = tag_base + 6'd4;
          tag_count = tag_count + 2'd1;
          phase = after_type(cur_type, tag_count);
        end
      end
      default: begin
        if (cur_type == ETYPE_IPV4 && pos == base + 9) begin
          ip_proto = b;
        end else if (cur_type == ETYPE_IPV6 && pos == base + 6) begin
          ip_proto = b;
        end
      end
    endcase
    if (cur_offset != OFFSET_MAX) begin
      cur_offset = cur_offset + 7'd1;
    end
    if (it.end_of_frame) begin
      done = 1'b1;
      base = int'(tag_base);
      if (phase != PH_L3) begin
        res.frame_class = CLASS_L2_SHORT;
      end else if (cur_type == ETYPE_IPV4) begin
        if (pos + 1 >= base + 20) begin
          res.frame_class = CLASS_IPV4;
          res.protocol    = ip_proto;
        end else begin
          res.frame_class = CLASS_IP_SHORT;
        end
      end else if (cur_type == ETYPE_IPV6) begin
        if (pos + 1 >= base + 40) begin
          res.frame_class = CLASS_IPV6;
          res.protocol    = ip_proto;
        end else begin
          res.frame_class = CLASS_IP_SHORT;
        end
      end else begin
        res.frame_class = CLASS_OTHER;
      end
      clear_frame();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t got;
    bit        done;
    int        errs;
    if (!rst_ni) begin
      clear_frame();
      class_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      errs = 0;
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (class_q.size() == 0) begin
          $display("%t: unexpected result item protocol %0h class %0d", $realtime,
                   got.protocol, got.frame_class);
          errs++;
        end else begin
          want = class_q.pop_front();
          if (got.protocol !== want.protocol) begin
            $display("%t: protocol expected %0h actual %0h", $realtime,
                     want.protocol, got.protocol);
            errs++;
          end
          if (got.frame_class !== want.frame_class) begin
            $display("%t: frame_class expected %0d actual %0d", $realtime,
                     want.frame_class, got.frame_class);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        parse_byte(in_data_i, done, want);
        if (done) begin
          class_q.push_back(want);
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= class_q.size();
    end
  end

endmodule

FILE: sim/tb_ethernet_l4_protocol_extract.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ethernet L4 protocol extract testbench
// Feeds byte-wide frames (plain, tagged, truncated, long and malformed) into
// the parser under several idle and stall mixes; the checker predicts and
// compares every result item.
// ----------------------------------------------------------------------------
module tb_ethernet_l4_protocol_extract;
  import l4px_pkg::*;

  localparam int CycleLimit = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int        fail_count;
  int        pending;
  int        cycle_count = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        sent_bytes = 0;
  logic [7:0] frame_q[$];

  ethernet_l4_protocol_extract DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  l4px_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL ethernet_l4_protocol_extract");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Builds one frame: MAC bytes, tags, inner ethertype, L3 header, then
  // padding or truncation to the requested length.
  task automatic make_frame(input int ntags, input logic [15:0] inner, input int hdr_len,
                            input logic [7:0] proto, input int len);
    logic [15:0] tag;
    int          base;
    frame_q.delete();
    repeat (12) frame_q.push_back(8'($urandom));
    for (int i = 0; i < ntags; i++) begin
      tag = $urandom_range(1) ? ETYPE_CTAG : ETYPE_STAG;
      frame_q.push_back(tag[15:8]);
      frame_q.push_back(tag[7:0]);
      frame_q.push_back(8'($urandom));
      frame_q.push_back(8'($urandom));
    end
    frame_q.push_back(inner[15:8]);
    frame_q.push_back(inner[7:0]);
    base = frame_q.size();
    repeat (hdr_len) frame_q.push_back(8'($urandom));
    if (inner == ETYPE_IPV4 && hdr_len > 9) frame_q[base + 9] = proto;
    if (inner == ETYPE_IPV6 && hdr_len > 6) frame_q[base + 6] = proto;
    while (frame_q.size() < len) frame_q.push_back(8'($urandom));
    while (frame_q.size() > len) void'(frame_q.pop_back());
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{frame_byte: b, end_of_frame: eof};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    sent_bytes++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      push_byte(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  task automatic random_frame();
    int          ntags;
    int          hdr_len;
    int          full;
    int          len;
    int          pick;
    logic [15:0] inner;
    ntags = $urandom_range(9) < 6 ? 0 : $urandom_range(1, 3);
    pick = $urandom_range(9);
    if (pick < 4) begin
      inner = ETYPE_IPV4;
      hdr_len = 20;
    end else if (pick < 7) begin
      inner = ETYPE_IPV6;
      hdr_len = 40;
    end else if (pick == 7) begin
      inner = $urandom_range(1) ? ETYPE_CTAG : ETYPE_STAG;
      hdr_len = $urandom_range(30);
    end else begin
      inner = 16'($urandom);
      hdr_len = $urandom_range(30);
    end
    full = 14 + 4 * ntags + hdr_len;
    pick = $urandom_range(9);
    if (pick < 6) len = full + $urandom_range(30);
    else if (pick < 8) len = full - $urandom_range(1, 3);
    else if (pick == 8) len = $urandom_range(1, full);
    else len = full + $urandom_range(60, 130);
    make_frame(ntags, inner, hdr_len, 8'($urandom), len);
    send_frame();
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int phase_start;
    idle_tab  = '{0, 82, 0, 28};
    stall_tab = '{0, 0, 82, 28};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_pct  = 28;
    stall_pct = 28;
    make_frame(0, ETYPE_IPV4, 20, 8'hFF, 1);         send_frame();
    make_frame(0, ETYPE_IPV4, 20, 8'hFF, 13);        send_frame();
    make_frame(0, ETYPE_IPV4, 20, 8'hFF, 14);        send_frame();
    make_frame(0, ETYPE_IPV4, 20, 8'hFF, 34);        send_frame();
    make_frame(0, ETYPE_IPV4, 20, 8'h01, 33);        send_frame();
    make_frame(0, ETYPE_IPV6, 40, 8'h00, 54);        send_frame();
    make_frame(0, ETYPE_IPV6, 40, 8'h3A, 53);        send_frame();
    make_frame(1, ETYPE_IPV4, 20, 8'h06, 17);        send_frame();
    make_frame(2, ETYPE_IPV4, 20, 8'h06, 42);        send_frame();
    make_frame(3, ETYPE_IPV4, 20, 8'h06, 60);        send_frame();
    make_frame(0, 16'h1234, 20, 8'h06, 60);          send_frame();
    make_frame(0, ETYPE_IPV4, 20, 8'h11, 200);       send_frame();
    make_frame(1, ETYPE_IPV6, 40, 8'h3A, 58);        send_frame();

    for (int p = 0; p < 4; p++) begin
      idle_pct    = idle_tab[p];
      stall_pct   = stall_tab[p];
      phase_start = sent_bytes;
      while (sent_bytes - phase_start < 240) random_frame();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS ethernet_l4_protocol_extract");
    end else begin
      $display("FAIL ethernet_l4_protocol_extract");
    end
    $finish;
  end

endmodule
